FILE: rtl/quad_bezier_stroke_tessellator_assert.svh
// Assertion macros shared by the tessellator modules.
// Each module that uses them has clk_i and rst_ni in scope.
`ifndef QUAD_BEZIER_STROKE_TESSELLATOR_ASSERT_SVH
`define QUAD_BEZIER_STROKE_TESSELLATOR_ASSERT_SVH

// Property checked every cycle out of reset.
`define QBST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies another in the next.
`define QBST_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: rtl/qbst_pkg.sv
package qbst_pkg;

  // Curve subdivision count.
  localparam int unsigned SEGMENTS = 24;
  localparam int unsigned IDX_W    = $clog2(SEGMENTS + 1);
  // Remainder accumulator of the t step: holds values below 2*SEGMENTS.
  localparam int unsigned REM_W    = $clog2(2 * SEGMENTS);

  localparam logic [16:0] T_ONE = 17'h10000;

  // Reciprocal of SEGMENTS for the t step split.
  localparam int unsigned RECIP_SH = 22;
  localparam int unsigned RECIP    = (1 << RECIP_SH) / SEGMENTS;
  localparam int unsigned PROD_W   = 17 + RECIP_SH + 1;

  // Offset magnitude never exceeds (w+1)/2, so 12 quotient bits.
  localparam int unsigned OFS_W  = 12;
  localparam int unsigned DCNT_W = $clog2(OFS_W);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] ctrl_x;
    logic signed [15:0] ctrl_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [11:0]        stroke_width;
    logic [16:0]        t_limit;
  } in_word_t;

  typedef struct packed {
    logic [4:0]         step_index;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic               zero_chord;
    logic               last;
  } out_word_t;

  // Classified segment: points, width and the t step as quotient/remainder.
  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
    logic [11:0]        w;
    logic [16:0]        tq;
    logic [REM_W-1:0]   tr;
  } job_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/qbst_front.sv
module qbst_front import qbst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_word_t in_data_i,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output job_t     job_o,
  output logic     job_push_o,
  input  logic     job_full_i
);

  logic              s1_vld_q, s1_vld_d;
  in_word_t          s1_q;
  logic [16:0]       s1_t_q;
  logic [PROD_W-1:0] s1_prod_q;
  logic              s2_vld_q, s2_vld_d;
  job_t              s2_q, s2_d;

  logic              s1_free, s2_free, accept;
  logic [16:0]       t_cl;
  logic [16:0]       q0;
  logic [17:0]       r0;

  assign s2_free    = !s2_vld_q || !job_full_i;
  assign s1_free    = !s1_vld_q || s2_free;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;
  assign job_push_o = s2_vld_q && !job_full_i;
  assign job_o      = s2_q;

  assign t_cl = (in_data_i.t_limit > T_ONE) ? T_ONE : in_data_i.t_limit;

  // t step = T / SEGMENTS by reciprocal, then one correction.
  always_comb begin
    q0   = s1_prod_q[RECIP_SH +: 17];
    r0   = {1'b0, s1_t_q} - 18'(18'(q0) * 18'(SEGMENTS));
    s2_d = s2_q;
    s2_d.sx = s1_q.start_x;
    s2_d.sy = s1_q.start_y;
    s2_d.cx = s1_q.ctrl_x;
    s2_d.cy = s1_q.ctrl_y;
    s2_d.ex = s1_q.end_x;
    s2_d.ey = s1_q.end_y;
    s2_d.w  = s1_q.stroke_width;
    if (r0 >= 18'(SEGMENTS)) begin
      s2_d.tq = q0 + 17'd1;
      s2_d.tr = REM_W'(r0 - 18'(SEGMENTS));
    end else begin
      s2_d.tq = q0;
      s2_d.tr = REM_W'(r0);
    end
  end

  always_comb begin
    s1_vld_d = s1_free ? (accept && (in_data_i.t_limit != '0)) : s1_vld_q;
    s2_vld_d = s2_free ? s1_vld_q : s2_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_q      <= in_data_i;
      s1_t_q    <= t_cl;
      s1_prod_q <= PROD_W'(PROD_W'(t_cl) * PROD_W'(RECIP));
    end
    if (s2_free) begin
      s2_q <= s2_d;
    end
  end

endmodule

FILE: rtl/qbst_queue.sv
`include "quad_bezier_stroke_tessellator_assert.svh"

module qbst_queue import qbst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t push_data_i,
  input  logic push_i,
  output logic full_o,
  output job_t head_o,
  output logic head_vld_o,
  input  logic pop_i
);

  localparam logic [QPTR_W:0] CNT_MAX = (QPTR_W + 1)'(QDEPTH);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == CNT_MAX);
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QPTR_W + 1)'(push_i) - (QPTR_W + 1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `QBST_ASSERT(a_push_room, push_i |-> cnt_q != CNT_MAX, "queue push while full")
  `QBST_ASSERT(a_pop_data, pop_i |-> cnt_q != '0, "queue pop while empty")
  `QBST_ASSERT(a_cnt_range, cnt_q <= CNT_MAX, "queue count out of range")

endmodule

FILE: rtl/qbst_back.sv
`include "quad_bezier_stroke_tessellator_assert.svh"

module qbst_back import qbst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_vld_i,
  output logic      job_pop_o,
  output out_word_t out_data_o,
  output logic      out_valid_o,
  input  logic      out_stall_i
);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_TSTEP = 11'b000_0000_0010,
    ST_ABC   = 11'b000_0000_0100,
    ST_MUL   = 11'b000_0000_1000,
    ST_SUM   = 11'b000_0001_0000,
    ST_SQ    = 11'b000_0010_0000,
    ST_SQRT  = 11'b000_0100_0000,
    ST_DLOAD = 11'b000_1000_0000,
    ST_DIV   = 11'b001_0000_0000,
    ST_EMIT0 = 11'b010_0000_0000,
    ST_EMIT  = 11'b100_0000_0000
  } state_e;

  localparam logic signed [51:0] HALF_LSB = 52'sh0_0000_8000_0000;
  localparam logic [49:0]        SQ_BIT0  = 50'(1) << 48;

  state_e             state_q, state_d;
  job_t               job_q, job_d;
  logic [IDX_W-1:0]   i_q, i_d;
  logic [16:0]        tq_q, tq_d;
  logic [REM_W-1:0]   tr_q, tr_d;
  logic signed [15:0] px_q, px_d, py_q, py_d, qx_q, qx_d, qy_q, qy_d;
  logic [32:0]        a_q, a_d, b_q, b_d, c_q, c_d;
  logic signed [49:0] pax_q, pax_d, pbx_q, pbx_d, pcx_q, pcx_d;
  logic signed [49:0] pay_q, pay_d, pby_q, pby_d, pcy_q, pcy_d;
  logic signed [16:0] dx_q, dx_d, dy_q, dy_d;
  logic [49:0]        rn_q, rn_d, rr_q, rr_d, rb_q, rb_d;
  logic [37:0]        remx_q, remx_d, remy_q, remy_d, dsh_q, dsh_d;
  logic [DCNT_W-1:0]  dcnt_q, dcnt_d;
  logic [OFS_W-1:0]   oxm_q, oxm_d, oym_q, oym_d;
  logic               zero_q, zero_d;
  out_word_t          out_q, out_d;
  logic               out_vld_q, out_vld_d;

  logic               out_free, out_load;
  logic [REM_W-1:0]   trs;
  logic [16:0]        u;
  logic signed [51:0] sum_x, sum_y;
  logic [33:0]        sq;
  logic [49:0]        trial;
  logic [16:0]        adx, ady;
  logic [24:0]        lf;
  logic               gex, gey;
  state_e             emit_st;
  logic               first_pair;
  logic signed [15:0] bx, by;
  logic signed [17:0] oxs, oys;

  assign out_free    = !out_vld_q || !out_stall_i;
  assign out_data_o  = out_q;
  assign out_valid_o = out_vld_q;

  // Edge points of the pair being emitted.
  always_comb begin
    first_pair = (state_q == ST_EMIT0);
    bx  = first_pair ? px_q : qx_q;
    by  = first_pair ? py_q : qy_q;
    oxs = dy_q[16] ? -18'(oxm_q) : 18'(oxm_q);
    oys = dx_q[16] ? -18'(oym_q) : 18'(oym_q);
    out_d            = out_q;
    out_d.step_index = first_pair ? 5'd0 : 5'(i_q);
    out_d.left_x     = sat16(18'(bx) + oxs);
    out_d.left_y     = sat16(18'(by) - oys);
    out_d.right_x    = sat16(18'(bx) - oxs);
    out_d.right_y    = sat16(18'(by) + oys);
    out_d.zero_chord = zero_q;
    out_d.last       = !first_pair && (i_q == IDX_W'(SEGMENTS));
  end

  always_comb begin
    state_d = state_q;
    job_d = job_q;   i_d = i_q;     tq_d = tq_q;   tr_d = tr_q;
    px_d = px_q;     py_d = py_q;   qx_d = qx_q;   qy_d = qy_q;
    a_d = a_q;       b_d = b_q;     c_d = c_q;
    pax_d = pax_q;   pbx_d = pbx_q; pcx_d = pcx_q;
    pay_d = pay_q;   pby_d = pby_q; pcy_d = pcy_q;
    dx_d = dx_q;     dy_d = dy_q;
    rn_d = rn_q;     rr_d = rr_q;   rb_d = rb_q;
    remx_d = remx_q; remy_d = remy_q; dsh_d = dsh_q; dcnt_d = dcnt_q;
    oxm_d = oxm_q;   oym_d = oym_q; zero_d = zero_q;
    job_pop_o = 1'b0;
    out_load  = 1'b0;
    trs   = tr_q + job_q.tr;
    u     = T_ONE - tq_q;
    sum_x = 52'(pax_q) + 52'(pbx_q) + 52'(pcx_q) + HALF_LSB;
    sum_y = 52'(pay_q) + 52'(pby_q) + 52'(pcy_q) + HALF_LSB;
    dx_d  = (state_q == ST_SQ) ? 17'(qx_q) - 17'(px_q) : dx_q;
    dy_d  = (state_q == ST_SQ) ? 17'(qy_q) - 17'(py_q) : dy_q;
    sq    = 34'(34'(dx_d * dx_d) + 34'(dy_d * dy_d));
    trial = rr_q + rb_q;
    adx   = dx_q[16] ? 17'(-dx_q) : 17'(dx_q);
    ady   = dy_q[16] ? 17'(-dy_q) : 17'(dy_q);
    lf    = rr_q[24:0];
    gex   = (remx_q >= dsh_q);
    gey   = (remy_q >= dsh_q);
    emit_st = (i_q == IDX_W'(1)) ? ST_EMIT0 : ST_EMIT;

    unique case (state_q)
      ST_IDLE: begin
        if (job_vld_i) begin
          job_pop_o = 1'b1;
          job_d   = job_i;
          px_d    = job_i.sx;
          py_d    = job_i.sy;
          i_d     = '0;
          tq_d    = '0;
          tr_d    = '0;
          state_d = ST_TSTEP;
        end
      end
      ST_TSTEP: begin
        // t_i = i*q + floor(i*r / SEGMENTS), kept incrementally
        i_d = i_q + 1'b1;
        if (trs >= REM_W'(SEGMENTS)) begin
          tq_d = tq_q + job_q.tq + 17'd1;
          tr_d = trs - REM_W'(SEGMENTS);
        end else begin
          tq_d = tq_q + job_q.tq;
          tr_d = trs;
        end
        state_d = ST_ABC;
      end
      ST_ABC: begin
        a_d = 33'(u * u);
        b_d = 33'(u * tq_q) << 1;
        c_d = 33'(tq_q * tq_q);
        state_d = ST_MUL;
      end
      ST_MUL: begin
        pax_d = 50'($signed({1'b0, a_q}) * job_q.sx);
        pbx_d = 50'($signed({1'b0, b_q}) * job_q.cx);
        pcx_d = 50'($signed({1'b0, c_q}) * job_q.ex);
        pay_d = 50'($signed({1'b0, a_q}) * job_q.sy);
        pby_d = 50'($signed({1'b0, b_q}) * job_q.cy);
        pcy_d = 50'($signed({1'b0, c_q}) * job_q.ey);
        state_d = ST_MUL == state_q ? ST_SUM : state_q;
      end
      ST_SUM: begin
        qx_d = sum_x[47:32];
        qy_d = sum_y[47:32];
        state_d = ST_SQ;
      end
      ST_SQ: begin
        if (sq == '0) begin
          zero_d  = 1'b1;
          oxm_d   = '0;
          oym_d   = '0;
          state_d = emit_st;
        end else begin
          zero_d  = 1'b0;
          rn_d    = {sq, 16'h0000};
          rr_d    = '0;
          rb_d    = SQ_BIT0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // one root bit per cycle
        if (rn_q >= trial) begin
          rn_d = rn_q - trial;
          rr_d = (rr_q >> 1) + rb_q;
        end else begin
          rr_d = rr_q >> 1;
        end
        rb_d = rb_q >> 2;
        if (rb_q == 50'd1) begin
          state_d = ST_DLOAD;
        end
      end
      ST_DLOAD: begin
        remx_d  = ((38'(ady) * 38'(job_q.w)) << 8) + 38'(lf);
        remy_d  = ((38'(adx) * 38'(job_q.w)) << 8) + 38'(lf);
        dsh_d   = 38'({lf, 1'b0}) << (OFS_W - 1);
        dcnt_d  = '0;
        oxm_d   = '0;
        oym_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // restoring divide, both offsets share the shifted divisor
        if (gex) begin
          remx_d = remx_q - dsh_q;
        end
        if (gey) begin
          remy_d = remy_q - dsh_q;
        end
        oxm_d  = {oxm_q[OFS_W-2:0], gex};
        oym_d  = {oym_q[OFS_W-2:0], gey};
        dsh_d  = dsh_q >> 1;
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCNT_W'(OFS_W - 1)) begin
          state_d = emit_st;
        end
      end
      ST_EMIT0: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (i_q == IDX_W'(SEGMENTS)) begin
            state_d = ST_IDLE;
          end else begin
            px_d    = qx_q;
            py_d    = qy_q;
            state_d = ST_TSTEP;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;   i_q <= i_d;     tq_q <= tq_d;   tr_q <= tr_d;
    px_q <= px_d;     py_q <= py_d;   qx_q <= qx_d;   qy_q <= qy_d;
    a_q <= a_d;       b_q <= b_d;     c_q <= c_d;
    pax_q <= pax_d;   pbx_q <= pbx_d; pcx_q <= pcx_d;
    pay_q <= pay_d;   pby_q <= pby_d; pcy_q <= pcy_d;
    dx_q <= dx_d;     dy_q <= dy_d;
    rn_q <= rn_d;     rr_q <= rr_d;   rb_q <= rb_d;
    remx_q <= remx_d; remy_q <= remy_d; dsh_q <= dsh_d; dcnt_q <= dcnt_d;
    oxm_q <= oxm_d;   oym_q <= oym_d; zero_q <= zero_d;
    if (out_load) begin
      out_q <= out_d;
    end
  end

  `QBST_ASSERT(a_last_step, out_vld_q && out_q.last |-> out_q.step_index == 5'(SEGMENTS), "last word off its step")
  `QBST_ASSERT(a_zero_flat, out_vld_q && out_q.zero_chord |-> out_q.left_x == out_q.right_x && out_q.left_y == out_q.right_y, "zero chord with offset")
  `QBST_ASSERT_NEXT(a_ofs_bound, state_q == ST_DIV && dcnt_q == DCNT_W'(OFS_W - 1), oxm_q <= 12'd2048 && oym_q <= 12'd2048, "offset above half width")

endmodule

FILE: rtl/quad_bezier_stroke_tessellator.sv
// Quadratic Bezier thick-stroke tessellator.
// Input channel (in_data_i/in_valid_i/in_stall_o): one word per curve segment,
// start/control/end points in Q12.4, stroke width Q8.4, t limit Q1.16.
// Output channel (out_data_o/out_valid_o/out_stall_i): SEGMENTS+1 words per
// segment, step 0..SEGMENTS, each a left/right edge pair of a triangle strip;
// last marks the final pair. A t limit of zero produces no words at all.
// Per chord the back end runs a t step, 4 multiply/sum stages, 25 root bits,
// a divide setup, 12 quotient bits and an emit, and starts the next segment
// only after the last pair is loaded; a zero-length chord skips root and divide.
// The bit-serial square root and the 12-step divider dominate this work.
// The front end (clamp, t step split) feeds a 4-word queue and keeps taking
// words until the queue and its two stages fill; then in_stall_o rises.
// When out_stall_i is high a valid output word holds and the back end waits to emit.
// Reset (rst_ni low, async) empties the pipe, queue and output register.
module quad_bezier_stroke_tessellator import qbst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output out_word_t out_data_o,
  output logic      out_valid_o,
  input  logic      out_stall_i
);

  job_t push_data, head;
  logic push, full, head_vld, pop;

  // classify: clamp t, drop empty segments, split t step
  qbst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .job_o      (push_data),
    .job_push_o (push),
    .job_full_i (full)
  );

  qbst_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_data_i (push_data),
    .push_i      (push),
    .full_o      (full),
    .head_o      (head),
    .head_vld_o  (head_vld),
    .pop_i       (pop)
  );

  // sample, chord, root, divide, emit
  qbst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head),
    .job_vld_i   (head_vld),
    .job_pop_o   (pop),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule
